@@ sv/x86_64_page_table_walker_assert.svh @@
// ----------------------------------------------------------------------------
// x86_64_page_table_walker_assert.svh
// Assertion macros for the page table walker. Define NO_ASSERTIONS to drop
// every check from the build.
// ----------------------------------------------------------------------------
`ifndef X86_64_PAGE_TABLE_WALKER_ASSERT_SVH
`define X86_64_PAGE_TABLE_WALKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset
`define PTW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page table walker: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page table walker: next-cycle check failed");

`else

`define PTW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/ptw_pkg.sv @@
// ----------------------------------------------------------------------------
// ptw_pkg
// Types, codes and helpers shared by the four-level page table walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptw_pkg;

  // Implemented physical address width (36..52)
  localparam int unsigned PHYS_ADDR_BITS = 48;

  localparam logic [63:0] FRAME_MASK =
    ((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'hFFF;
  localparam logic [63:0] MASK_1G = 64'h3FFF_FFFF;
  localparam logic [63:0] MASK_2M = 64'h1F_FFFF;
  localparam logic [63:0] MASK_4K = 64'hFFF;

  // Entry bit positions
  localparam int unsigned ENT_PRESENT = 0;
  localparam int unsigned ENT_PS_BIT  = 7;

  // Word kinds on the input channel
  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_ENTRY   = 1'b1
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_READ       = 2'd0,
    ST_DONE       = 2'd1,
    ST_FAULT      = 2'd2,
    ST_UNEXPECTED = 2'd3
  } status_t;

  // Table levels
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  // Page size codes
  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  typedef struct packed {
    kind_t        kind;
    logic [47:0]  vaddr;
    logic [51:0]  directory_base;
    logic [63:0]  table_entry;
  } in_word_t;

  typedef struct packed {
    status_t      status;
    logic [47:0]  read_address;
    logic [47:0]  paddr;
    logic [1:0]   map_size;
    logic [1:0]   fault_level;
  } out_word_t;

  // Walk state carried between words
  typedef struct packed {
    logic         active;
    logic [1:0]   level;
    logic [47:0]  held;
  } walk_state_t;

  // Byte offset of the entry for a level inside its 4 KiB table
  function automatic logic [11:0] entry_offset(input logic [47:0] va,
                                               input logic [1:0] level);
    logic [8:0] idx;
    unique case (level)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return {idx, 3'b000};
  endfunction

endpackage

@@ sv/x86_64_page_table_walker.sv @@
// ----------------------------------------------------------------------------
// x86_64_page_table_walker
// Four-level x86-64 page table walker: turns translate requests and returned
// table entries into entry read requests, translations, faults or unexpected-word codes.
// ----------------------------------------------------------------------------
//   Channel  Ports                          Word
//   input    in_valid / in_ready / in_data   request or returned entry
//   output   out_valid / out_ready / out_data status and addresses
//
// Each accepted word yields one result word in the next cycle, from the output
// register. A word can be taken every cycle while out_ready is high; the single
// output register decides the rate. While the output word stalls, in_ready drops
// and nothing moves. Reset clears the walk state (idle) and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "x86_64_page_table_walker_assert.svh"

module x86_64_page_table_walker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptw_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ptw_pkg::out_word_t  out_data
);

  ptw_pkg::walk_state_t state_r;
  ptw_pkg::walk_state_t state_nxt;
  ptw_pkg::out_word_t   res_nxt;
  ptw_pkg::out_word_t   out_data_r;
  logic                 out_valid_r;
  logic                 in_fire;

  // Accept while the output register is empty or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ptw_step u_step (
    .word_i  (in_data),
    .state_i (state_r),
    .res_o   (res_nxt),
    .state_o (state_nxt)
  );

  // Advance walk state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Hold or refill the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

  `PTW_ASSERT_NEXT(a_walk_ends, clk, rst_n,
    in_fire && (res_nxt.status == ptw_pkg::ST_DONE || res_nxt.status == ptw_pkg::ST_FAULT),
    !state_r.active)
  `PTW_ASSERT_NEXT(a_read_keeps_walk, clk, rst_n,
    in_fire && res_nxt.status == ptw_pkg::ST_READ, state_r.active)
  `PTW_ASSERT_NEXT(a_unexpected_no_change, clk, rst_n,
    in_fire && res_nxt.status == ptw_pkg::ST_UNEXPECTED, $stable(state_r))
  `PTW_ASSERT_NOW(a_read_addr_only_on_read, clk, rst_n,
    out_valid_r && out_data_r.status != ptw_pkg::ST_READ, out_data_r.read_address == 48'd0)

endmodule

@@ sv/ptw_step.sv @@
// ----------------------------------------------------------------------------
// ptw_step
// One walk step: checks a request or a returned entry against the walk state
// and forms the result word and the next state. Purely combinational.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptw_step (
  input  ptw_pkg::in_word_t     word_i,
  input  ptw_pkg::walk_state_t  state_i,
  output ptw_pkg::out_word_t    res_o,
  output ptw_pkg::walk_state_t  state_o
);

  logic [63:0] cr3_frame;
  logic [63:0] frame;
  logic [63:0] held_ext;
  logic [63:0] addr;
  logic [1:0]  level_inc;
  logic        present;
  logic        big;

  assign cr3_frame = {12'd0, word_i.directory_base} & ptw_pkg::FRAME_MASK;
  assign frame     = word_i.table_entry & ptw_pkg::FRAME_MASK;
  assign held_ext  = {16'd0, state_i.held};
  assign level_inc = state_i.level + 2'd1;
  assign present   = word_i.table_entry[ptw_pkg::ENT_PRESENT];
  assign big       = word_i.table_entry[ptw_pkg::ENT_PS_BIT];

  // Decide the step outcome; order of checks follows the walk rules
  always_comb begin
    res_o   = '0;
    state_o = state_i;
    addr    = '0;
    if (word_i.kind == ptw_pkg::KIND_REQUEST) begin
      if (state_i.active) begin
        res_o.status = ptw_pkg::ST_UNEXPECTED;
      end else begin
        addr = cr3_frame + {52'd0,
               ptw_pkg::entry_offset(word_i.vaddr, ptw_pkg::LVL_PML4)};
        res_o.status       = ptw_pkg::ST_READ;
        res_o.read_address = addr[47:0];
        state_o.active     = 1'b1;
        state_o.level      = ptw_pkg::LVL_PML4;
        state_o.held       = word_i.vaddr;
      end
    end else if (!state_i.active) begin
      res_o.status = ptw_pkg::ST_UNEXPECTED;
    end else if (!present) begin
      res_o.status      = ptw_pkg::ST_FAULT;
      res_o.fault_level = state_i.level;
      state_o.active    = 1'b0;
      state_o.level     = ptw_pkg::LVL_PML4;
    end else if (state_i.level == ptw_pkg::LVL_PDPT && big) begin
      addr = (frame & ~ptw_pkg::MASK_1G) | (held_ext & ptw_pkg::MASK_1G);
      res_o.status   = ptw_pkg::ST_DONE;
      res_o.paddr    = addr[47:0];
      res_o.map_size = ptw_pkg::PS_1G;
      state_o.active = 1'b0;
      state_o.level  = ptw_pkg::LVL_PML4;
    end else if (state_i.level == ptw_pkg::LVL_PD && big) begin
      addr = (frame & ~ptw_pkg::MASK_2M) | (held_ext & ptw_pkg::MASK_2M);
      res_o.status   = ptw_pkg::ST_DONE;
      res_o.paddr    = addr[47:0];
      res_o.map_size = ptw_pkg::PS_2M;
      state_o.active = 1'b0;
      state_o.level  = ptw_pkg::LVL_PML4;
    end else if (state_i.level == ptw_pkg::LVL_PT) begin
      addr = frame | (held_ext & ptw_pkg::MASK_4K);
      res_o.status   = ptw_pkg::ST_DONE;
      res_o.paddr    = addr[47:0];
      res_o.map_size = ptw_pkg::PS_4K;
      state_o.active = 1'b0;
      state_o.level  = ptw_pkg::LVL_PML4;
    end else begin
      // Descend one level
      addr = frame + {52'd0, ptw_pkg::entry_offset(state_i.held, level_inc)};
      res_o.status       = ptw_pkg::ST_READ;
      res_o.read_address = addr[47:0];
      state_o.level      = level_inc;
    end
  end

endmodule
